[hdl/htfd_pkg.sv]
// Shared types and constants for the head/tail frame deframer.
// No dependencies; imported by every module of the block.
package htfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;

  localparam logic [BYTE_W-1:0] HEAD_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] TAIL_MARK = 8'h0D;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a received byte
    ST_UPD,    // write the byte, update sum and fill, fetch oldest byte
    ST_HUNT,   // test head and tail marks, fetch checksum byte
    ST_CHKRD,  // latch checksum byte, start the modulo unit
    ST_MOD,    // wait for the modulo unit
    ST_ERD,    // fetch the next inner byte
    ST_EOUT    // hand the inner byte to the output register
  } state_e;

  // Status returned by the modulo 255 unit.
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] rem;
  } mod_stat_t;

endpackage

[hdl/htfd_window_ram.sv]
// Byte window store: one write port, one registered read port.
// Depends on htfd_pkg for the byte width.
module htfd_window_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [htfd_pkg::BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [htfd_pkg::BYTE_W-1:0] rdata_o
);
  import htfd_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/htfd_mod255.sv]
// Iterative modulo 255 unit: folds the high bits onto the low byte, one add per cycle.
// Depends on htfd_pkg for the status struct.
module htfd_mod255 #(
  parameter int unsigned OP_W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [OP_W-1:0]     operand_i,
  output htfd_pkg::mod_stat_t stat_o
);
  import htfd_pkg::*;

  // Two folds bring any operand of up to 16 bits to 255 or below.
  localparam logic [OP_W-1:0] MOD_BASE  = OP_W'(255);
  localparam logic [1:0]      LAST_STEP = 2'd2;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [1:0]      step_q, step_d;
  logic [OP_W-1:0] rem_q, rem_d;
  logic [OP_W-1:0] fold;

  // 256 is 1 modulo 255: add the high part onto the low byte.
  assign fold = OP_W'(rem_q[BYTE_W-1:0]) + OP_W'(rem_q[OP_W-1:BYTE_W]);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = operand_i;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      if (step_q == LAST_STEP) begin
        // Only 255 itself is left unreduced after the folds.
        if (rem_q == MOD_BASE) begin
          rem_d = '0;
        end
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d = fold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q[BYTE_W-1:0];

endmodule

[hdl/head_tail_frame_deframer_unit.sv]
// Head/tail frame deframer: top level with the byte sequencer and output register.
// Depends on htfd_pkg, htfd_window_ram and htfd_mod255.
//
// Usage: feed received bytes on rx_byte_i with rx_valid_i; a beat is taken
// when rx_stall_o is low. The block keeps the last FRAME_LEN bytes since the
// previous frame. A frame is found when the window is full, the oldest byte
// is 0xFF and the newest is 0x0D. Its inner bytes then leave on the output
// channel (payload_byte_o, byte_index_o, last_byte_o, checksum_ok_o) one beat
// at a time, each carrying the modulo 255 checksum verdict; the window empties.
// Sequence: a byte without a frame passes through accept, window update and
// mark test, paced by the single registered read port of the window store.
// A found frame then latches the checksum byte, runs the modulo unit (two
// folds of the high sum bits onto the low byte, a final correction and the
// done flag), then reads the store and loads the output for each inner byte.
// rx_stall_o is high whenever a byte is being worked on.
// A stall from the receiver holds the output beat and the sequencer; only
// one result waits in the output register while the next byte is fetched.
// Reset empties the window and clears the output valid; store contents stay
// undefined and are never used before being written.
module head_tail_frame_deframer_unit #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [htfd_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          rx_valid_i,
  output logic                          rx_stall_o,
  output logic [htfd_pkg::BYTE_W-1:0]   payload_byte_o,
  output logic [htfd_pkg::IDX_W-1:0]    byte_index_o,
  output logic                          last_byte_o,
  output logic                          checksum_ok_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);
  import htfd_pkg::*;

  localparam int unsigned AW    = $clog2(FRAME_LEN);
  localparam int unsigned CW    = $clog2(FRAME_LEN + 1);
  localparam int unsigned SUM_W = $clog2(FRAME_LEN * 255 + 1);
  localparam int unsigned SEL_W = IDX_W + 1;

  localparam logic [CW-1:0]    FILL_FULL = CW'(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 4);
  localparam logic [IDX_W-1:0] CHK_OFS   = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] ONE_OFS   = IDX_W'(1);

  // Circular address: base plus offset, both below FRAME_LEN, wrapped once.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0]    base,
                                             input logic [IDX_W-1:0] ofs);
    logic [SEL_W-1:0] s;
    s = SEL_W'(base) + SEL_W'(ofs);
    if (s >= SEL_W'(FRAME_LEN)) begin
      s = s - SEL_W'(FRAME_LEN);
    end
    return s[AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [CW-1:0]     fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [BYTE_W-1:0] chk_q, chk_d;
  logic              ok_q, ok_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;
  logic              out_ok_q;

  logic              mem_we;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic              mod_start;
  logic [SUM_W-1:0]  mod_operand;
  mod_stat_t         mod_stat;

  logic rx_accept;
  logic out_free;
  logic out_load;
  logic frame_hit;
  logic idx_last;

  assign rx_accept = rx_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign frame_hit = (fill_q == FILL_FULL) && (byte_q == TAIL_MARK) &&
                     (mem_rdata == HEAD_MARK);
  assign idx_last  = (idx_q == LAST_IDX);

  htfd_window_ram #(
    .DEPTH (FRAME_LEN),
    .AW    (AW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (byte_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  htfd_mod255 #(
    .OP_W (SUM_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .operand_i (mod_operand),
    .stat_o    (mod_stat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (rx_accept) begin
        state_d = ST_UPD;
      end
      ST_UPD:   state_d = ST_HUNT;
      ST_HUNT:  state_d = frame_hit ? ST_CHKRD : ST_IDLE;
      ST_CHKRD: state_d = ST_MOD;
      ST_MOD:   if (mod_stat.done) begin
        state_d = ST_ERD;
      end
      ST_ERD:   state_d = ST_EOUT;
      ST_EOUT:  if (out_free) begin
        state_d = idx_last ? ST_IDLE : ST_ERD;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and state updates.
  always_comb begin
    fill_d      = fill_q;
    sum_d       = sum_q;
    wp_d        = wp_q;
    byte_d      = byte_q;
    chk_d       = chk_q;
    ok_d        = ok_q;
    idx_d       = idx_q;
    mem_we      = 1'b0;
    mem_raddr   = wp_q;
    mod_start   = 1'b0;
    mod_operand = sum_q - SUM_W'(mem_rdata);
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // Fetch the byte about to be overwritten.
        byte_d    = rx_byte_i;
        mem_raddr = wp_q;
      end
      ST_UPD: begin
        mem_we = 1'b1;
        if (fill_q == FILL_FULL) begin
          sum_d = sum_q - SUM_W'(mem_rdata) + SUM_W'(byte_q);
        end else begin
          sum_d  = sum_q + SUM_W'(byte_q);
          fill_d = fill_q + CW'(1);
        end
        wp_d      = wrap_add(wp_q, ONE_OFS);
        // Oldest byte now sits at the next write slot.
        mem_raddr = wrap_add(wp_q, ONE_OFS);
      end
      ST_HUNT: begin
        mem_raddr = wrap_add(wp_q, CHK_OFS);
      end
      ST_CHKRD: begin
        // Head mark cancels itself: total is the sum less the checksum byte.
        chk_d     = mem_rdata;
        mod_start = 1'b1;
      end
      ST_MOD: begin
        if (mod_stat.done) begin
          ok_d  = (mod_stat.rem == chk_q);
          idx_d = '0;
        end
      end
      ST_ERD: begin
        mem_raddr = wrap_add(wp_q, idx_q + ONE_OFS);
      end
      ST_EOUT: begin
        // Hold the read address so the data stays put under a stall.
        mem_raddr = wrap_add(wp_q, idx_q + ONE_OFS);
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + ONE_OFS;
          if (idx_last) begin
            fill_d = '0;
            sum_d  = '0;
            wp_d   = '0;
          end
        end
      end
      default: begin
        mem_raddr = wp_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      sum_q       <= '0;
      wp_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      wp_q        <= wp_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    chk_q  <= chk_d;
    ok_q   <= ok_d;
    if (out_load) begin
      out_byte_q <= mem_rdata;
      out_idx_q  <= idx_q;
      out_last_q <= idx_last;
      out_ok_q   <= ok_q;
    end
  end

  assign rx_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign last_byte_o    = out_last_q;
  assign checksum_ok_o  = out_ok_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill count beyond frame length");

  a_mod_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_stat.done |-> (state_q == ST_MOD))
    else $error("modulo result arrived outside its wait state");

  a_mod_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_stat.done |-> (mod_stat.rem != HEAD_MARK))
    else $error("modulo remainder not reduced below 255");

  a_empty_after_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && idx_last) |=> (fill_q == '0) && (wp_q == '0) &&
                              (state_q == ST_IDLE))
    else $error("window not emptied after the last inner byte");

  a_load_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule
